@@ rtl/naive_bayes_class_scorer_defines.svh @@
// assertion macros shared by the naive Bayes class scorer
`ifndef NAIVE_BAYES_CLASS_SCORER_DEFINES_SVH
`define NAIVE_BAYES_CLASS_SCORER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define NBCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define NBCS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nbcs_pkg.sv @@
// shared types and constants of the naive Bayes class scorer
`default_nettype none

package nbcs_pkg;

  // request codes
  typedef enum logic [1:0] {
    FUNC_WEIGHT = 2'd0,
    FUNC_PRIOR  = 2'd1,
    FUNC_SAMPLE = 2'd2
  } func_t;

  localparam int VALUE_W  = 16;
  localparam int COUNT_W  = 16;
  localparam int SCORE_W  = 48;
  localparam int CONFIG_W = 5;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  // controller to datapath commands
  typedef struct packed {
    logic wr_weight;  // store table_value in the weight memory
    logic wr_prior;   // store table_value as a class prior
    logic latch;      // capture a sample count
    logic first;      // captured count opens a new sample
    logic rd_en;      // issue a weight read for the class index
    logic cmp_init;   // seed the minimum search with class 0
    logic cmp_step;   // compare the indexed class with the minimum
    logic out_load;   // move the minimum into the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;   // result register can take a new result this cycle
  } status_t;

endpackage

`default_nettype wire

@@ rtl/nbcs_ram.sv @@
// generic single write, single read RAM with registered read data
`default_nettype none

module nbcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/nbcs_datapath.sv @@
// datapath: weight memory, priors, shared multiply-accumulate, min search, result register
`default_nettype none

module nbcs_datapath
  import nbcs_pkg::*;
#(
  parameter int MAX_CLASSES  = 16,
  parameter int MAX_FEATURES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  input  wire logic [(MAX_CLASSES > 1 ? $clog2(MAX_CLASSES) : 1)-1:0] cls_idx,
  output status_t                    st,
  input  wire logic [3:0]            class_id,
  input  wire logic [7:0]            feature_id,
  input  wire logic [VALUE_W-1:0]    table_value,
  input  wire logic signed [COUNT_W-1:0] feature_count,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [3:0]                 predicted_class,
  output logic [SCORE_W-1:0]         best_score
);

  localparam int CBITS = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int FBITS = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int DEPTH = MAX_CLASSES * (2 ** FBITS);
  localparam int PROD_W = (COUNT_W - 1) + VALUE_W;

  logic                     cls_ok, feat_ok;
  logic [CBITS-1:0]         wr_cls;
  logic [FBITS-1:0]         wr_feat;
  logic [VALUE_W-1:0]       weight_rd;
  logic                     weight_we;

  // captured sample count
  logic [FBITS-1:0]         feat_reg;
  logic [COUNT_W-2:0]       cnt_reg;
  logic                     use_reg;
  logic                     first_reg;

  // multiply-accumulate pipeline
  logic                     v1, v2;
  logic [CBITS-1:0]         k1, k2;
  logic [PROD_W-1:0]        prod;

  logic [VALUE_W-1:0]       priors [MAX_CLASSES];
  logic [SCORE_W-1:0]       scores [MAX_CLASSES];
  logic [CBITS-1:0]         rd_idx;
  logic [SCORE_W-1:0]       score_rd;
  logic [SCORE_W-1:0]       base;
  logic [SCORE_W:0]         sum;
  logic [SCORE_W-1:0]       acc_next;

  // minimum search
  logic [CBITS-1:0]         best_idx;
  logic [SCORE_W-1:0]       best_val;

  // address checks on load requests
  assign cls_ok    = 32'(class_id) < MAX_CLASSES;
  assign feat_ok   = 32'(feature_id) < MAX_FEATURES;
  assign wr_cls    = CBITS'(class_id);
  assign wr_feat   = FBITS'(feature_id);
  assign weight_we = cmd.wr_weight && cls_ok && feat_ok;

  nbcs_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_weight_ram (
    .clk    (clk),
    .wr_en  (weight_we),
    .wr_addr({wr_cls, wr_feat}),
    .wr_data(table_value),
    .rd_en  (cmd.rd_en),
    .rd_addr({cls_idx, feat_reg}),
    .rd_data(weight_rd)
  );

  // one score read port, shared by accumulate and search
  assign rd_idx   = (cmd.cmp_init || cmd.cmp_step) ? cls_idx : k2;
  assign score_rd = scores[rd_idx];

  // saturating accumulate, seeded by the prior on the first count
  assign base     = first_reg ? SCORE_W'(priors[k2]) : score_rd;
  assign sum      = {1'b0, base} + (SCORE_W + 1)'(prod);
  assign acc_next = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];

  assign st.out_free = !out_valid || out_ready;

  // capture count, prior writes, pipeline payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      feat_reg  <= wr_feat;
      cnt_reg   <= feature_count[COUNT_W-2:0];
      use_reg   <= (feature_count > 0) && feat_ok;
      first_reg <= cmd.first;
    end
    if (cmd.wr_prior && cls_ok) begin
      priors[wr_cls] <= table_value;
    end
    k1   <= cls_idx;
    k2   <= k1;
    prod <= use_reg ? PROD_W'(cnt_reg) * PROD_W'(weight_rd) : '0;
    if (v2) begin
      scores[k2] <= acc_next;
    end
    if (cmd.cmp_init) begin
      best_idx <= '0;
      best_val <= score_rd;
    end else if (cmd.cmp_step && (best_val > score_rd)) begin
      best_idx <= cls_idx;
      best_val <= score_rd;
    end
    if (cmd.out_load) begin
      predicted_class <= 4'(best_idx);
      best_score      <= best_val;
    end
  end

  // pipeline valids and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/nbcs_controller.sv @@
// controller: request decode, class sweep, drain, minimum search and result hand-off
`default_nettype none

module nbcs_controller
  import nbcs_pkg::*;
#(
  parameter int MAX_CLASSES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CONFIG_W-1:0]   cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            func,
  input  wire logic                  last_feature,
  output cmd_t                       cmd,
  output logic [(MAX_CLASSES > 1 ? $clog2(MAX_CLASSES) : 1)-1:0] cls_idx,
  input  wire status_t               st
);

  localparam int CBITS = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_CMP,
    S_DONE
  } state_t;

  state_t                state;
  logic                  drain;
  logic                  last_reg;
  logic                  sample_start;
  logic [CONFIG_W-1:0]   num_classes;
  logic [CBITS-1:0]      last_cls;

  // highest class index compared, with num_classes clamped to a legal count
  always_comb begin
    if (num_classes == '0) begin
      last_cls = '0;
    end else if (32'(num_classes) > MAX_CLASSES) begin
      last_cls = CBITS'(MAX_CLASSES - 1);
    end else begin
      last_cls = CBITS'(num_classes - CONFIG_W'(1));
    end
  end

  assign in_ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd       = '0;
    cmd.first = sample_start;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_WEIGHT: cmd.wr_weight = 1'b1;
            FUNC_PRIOR:  cmd.wr_prior  = 1'b1;
            FUNC_SAMPLE: cmd.latch     = 1'b1;
            default:     cmd.latch     = 1'b0;
          endcase
        end
      end
      S_MAC:   cmd.rd_en = 1'b1;
      S_DRAIN: cmd.rd_en = 1'b0;
      S_CMP: begin
        cmd.cmp_init = (cls_idx == '0);
        cmd.cmp_step = (cls_idx != '0);
      end
      S_DONE:  cmd.out_load = st.out_free;
      default: cmd.rd_en = 1'b0;
    endcase
  end

  // state, class counter and configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cls_idx      <= '0;
      drain        <= 1'b0;
      last_reg     <= 1'b0;
      sample_start <= 1'b1;
      num_classes  <= CONFIG_W'(2);
    end else begin
      if (cfg_wr_en) begin
        num_classes <= cfg_wr_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && func == FUNC_SAMPLE) begin
            last_reg     <= last_feature;
            sample_start <= last_feature;
            cls_idx      <= '0;
            state        <= S_MAC;
          end
        end
        S_MAC: begin
          if (cls_idx == CBITS'(MAX_CLASSES - 1)) begin
            cls_idx <= '0;
            drain   <= 1'b0;
            state   <= S_DRAIN;
          end else begin
            cls_idx <= cls_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          drain <= 1'b1;
          if (drain) begin
            state <= last_reg ? S_CMP : S_IDLE;
          end
        end
        S_CMP: begin
          if (cls_idx == last_cls) begin
            state <= S_DONE;
          end else begin
            cls_idx <= cls_idx + 1'b1;
          end
        end
        S_DONE: begin
          if (st.out_free) begin
            cls_idx <= '0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/naive_bayes_class_scorer.sv @@
// top level of the multinomial naive Bayes class scorer
// Load requests (weight or prior) are written while the block is idle. A sample
// count request makes the single weight memory read port and the single
// multiply-accumulate unit visit one class per cycle over all MAX_CLASSES
// classes, followed by a pipeline drain. The count flagged last adds a minimum
// search over the compared classes (clamped num_classes) and a move of the
// result into the output register; a result still waiting there does not hold
// up later requests until the next result is ready. Weights and priors read
// before they were written give undefined scores. num_classes may be written
// only while no sample is in progress.
`default_nettype none
`include "naive_bayes_class_scorer_defines.svh"

module naive_bayes_class_scorer
  import nbcs_pkg::*;
#(
  parameter int MAX_CLASSES  = 16,
  parameter int MAX_FEATURES = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [CONFIG_W-1:0]       cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                func,
  input  wire logic [3:0]                class_id,
  input  wire logic [7:0]                feature_id,
  input  wire logic [VALUE_W-1:0]        table_value,
  input  wire logic signed [COUNT_W-1:0] feature_count,
  input  wire logic                      last_feature,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [3:0]                     predicted_class,
  output logic [SCORE_W-1:0]             best_score
);

  localparam int CBITS = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  cmd_t             cmd;
  status_t          st;
  logic [CBITS-1:0] cls_idx;

  nbcs_controller #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .last_feature(last_feature),
    .cmd         (cmd),
    .cls_idx     (cls_idx),
    .st          (st)
  );

  nbcs_datapath #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_FEATURES(MAX_FEATURES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cls_idx        (cls_idx),
    .st             (st),
    .class_id       (class_id),
    .feature_id     (feature_id),
    .table_value    (table_value),
    .feature_count  (feature_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .predicted_class(predicted_class),
    .best_score     (best_score)
  );

  // a load request never produces a result
  `NBCS_ASSERT_NXT(a_load_no_result,
    in_valid && in_ready && func != FUNC_SAMPLE, !$rose(out_valid),
    "result appeared after a load request")

  // a sample count occupies the block for the class sweep
  `NBCS_ASSERT_NXT(a_sample_busy,
    in_valid && in_ready && func == FUNC_SAMPLE, !in_ready,
    "new request taken during the class sweep")

  // a fresh result names a class that exists
  `NBCS_ASSERT_IMP(a_class_range,
    $rose(out_valid), 32'(predicted_class) < MAX_CLASSES,
    "predicted class out of range")

endmodule

`default_nettype wire
